// ----- rtl/wrpd_pkg.sv -----
// Shared constants, register indexes and controller/datapath interface types.
package wrpd_pkg;

  localparam int SENSORS      = 8;
  localparam int WINDOW_DEPTH = 16;

  localparam int SENS_W    = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int SLOT_W    = $clog2(WINDOW_DEPTH);
  localparam int IDX_W     = 5;
  localparam int LEN_W     = (SLOT_W + 1 > 5) ? SLOT_W + 1 : 5;
  localparam int ADDR_W    = SLOT_W + SENS_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RISE_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIP_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_VALUE = 3'd6;

  localparam logic MODE_SAMPLE  = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_stall;
  } dp_status_t;

endpackage

// ----- rtl/wrpd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module wrpd_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/wrpd_ctrl.sv -----
// Controller: two-state sequencer, window read then update and result load.
module wrpd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wrpd_pkg::dp_status_t status_i,
  output wrpd_pkg::ctrl_cmd_t  cmd_o
);
  import wrpd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!status_i.out_stall) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/wrpd_datapath.sv -----
// Datapath: config registers, window store, per-sensor state and result register.
module wrpd_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wrpd_pkg::ctrl_cmd_t                 cmd_i,
  output wrpd_pkg::dp_status_t                status_o,
  input  logic                                cfg_we_i,
  input  logic [wrpd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wrpd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                mode_i,
  input  logic [2:0]                          sensor_index_i,
  input  logic [9:0]                          sensor_value_i,
  input  logic [9:0]                          dark_value_i,
  input  logic [31:0]                         timestamp_i,
  input  logic                                last_of_set_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                sensor_high_o,
  output logic                                rise_found_o,
  output logic                                signal_found_o,
  output logic signed [10:0]                  delta_rise_o,
  output logic [31:0]                         pulse_time_o
);
  import wrpd_pkg::*;

  // configuration
  logic signed [10:0] rise_thr_q, dip_thr_q, peak_thr_q;
  logic [31:0]        pulse_min_q, pulse_max_q;
  logic [4:0]         win_len_q;
  logic [9:0]         cfg_fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_thr_q  <= '0;
      dip_thr_q   <= '0;
      peak_thr_q  <= '0;
      pulse_min_q <= '0;
      pulse_max_q <= '0;
      win_len_q   <= 5'd1;
      cfg_fill_q  <= 10'd1023;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_RISE_THR:   rise_thr_q  <= cfg_data_i[10:0];
        CFG_DIP_THR:    dip_thr_q   <= cfg_data_i[10:0];
        CFG_PEAK_THR:   peak_thr_q  <= cfg_data_i[10:0];
        CFG_PULSE_MIN:  pulse_min_q <= cfg_data_i[31:0];
        CFG_PULSE_MAX:  pulse_max_q <= cfg_data_i[31:0];
        CFG_WIN_LEN:    win_len_q   <= cfg_data_i[4:0];
        CFG_FILL_VALUE: cfg_fill_q  <= cfg_data_i[9:0];
        default: begin
        end
      endcase
    end
  end

  // captured item
  logic              mode_q, last_q;
  logic [IDX_W-1:0]  idx_q;
  logic [9:0]        value_q, dark_q;
  logic [31:0]       ts_q;
  logic [ADDR_W-1:0] addr_q;

  // state
  logic [SLOT_W-1:0]                   slot_q, slot_d;
  logic [RAM_DEPTH-1:0]                valid_q, valid_d;
  logic [9:0]                          fill_q, fill_d;
  logic [SENSORS-1:0][9:0]             peak_q, peak_d;
  logic [SENSORS-1:0][31:0]            rise_q, rise_d;
  logic [SENSORS-1:0]                  high_q, high_d;
  logic [WINDOW_DEPTH-1:0][31:0]       stime_q, stime_d;

  logic [IDX_W-1:0]  in_idx_ext;
  logic [ADDR_W-1:0] rd_addr;
  logic [9:0]        ram_rdata;
  logic              ram_we;

  assign in_idx_ext = IDX_W'(sensor_index_i);
  assign rd_addr    = {slot_q, in_idx_ext[SENS_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q  <= mode_i;
      idx_q   <= in_idx_ext;
      value_q <= sensor_value_i;
      dark_q  <= dark_value_i;
      ts_q    <= timestamp_i;
      last_q  <= last_of_set_i;
      addr_q  <= rd_addr;
    end
  end

  wrpd_ram #(
    .WIDTH (10),
    .DEPTH (RAM_DEPTH)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (value_q),
    .re_i    (cmd_i.capture),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // sample evaluation
  logic [SENS_W-1:0]  ix;
  logic               idx_ok, restart;
  logic [9:0]         stored, peak_cur, peak_max;
  logic signed [10:0] delta;
  logic signed [11:0] peak_diff;
  logic               high_cur, rise_c, fall_c, high_new, peak_ok, pt_sel, sig_c;
  logic [31:0]        ptime_raw;
  logic [LEN_W-1:0]   wl_ext, eff_len, next_slot;

  assign ix        = idx_q[SENS_W-1:0];
  assign idx_ok    = idx_q < IDX_W'(SENSORS);
  assign restart   = (mode_q == MODE_RESTART);
  assign stored    = valid_q[addr_q] ? ram_rdata : fill_q;
  assign delta     = $signed({1'b0, value_q}) - $signed({1'b0, stored});
  assign peak_cur  = peak_q[ix];
  assign peak_max  = (value_q > peak_cur) ? value_q : peak_cur;
  assign high_cur  = high_q[ix];
  assign rise_c    = !high_cur && (delta >= rise_thr_q);
  assign fall_c    = high_cur && (delta <= dip_thr_q);
  assign high_new  = rise_c || (high_cur && !fall_c);
  assign peak_diff = $signed({2'b00, peak_max}) - $signed({2'b00, dark_q});
  assign peak_ok   = peak_diff >= 12'(peak_thr_q);
  assign ptime_raw = ts_q - rise_q[ix];
  assign pt_sel    = rise_c && peak_ok;
  assign sig_c     = pt_sel && (ptime_raw >= pulse_min_q) && (ptime_raw <= pulse_max_q);

  assign wl_ext    = LEN_W'(win_len_q);
  assign eff_len   = (wl_ext == '0) ? LEN_W'(1) :
                     (wl_ext > LEN_W'(WINDOW_DEPTH)) ? LEN_W'(WINDOW_DEPTH) : wl_ext;
  assign next_slot = LEN_W'(slot_q) + LEN_W'(1);

  assign ram_we = cmd_i.exec && !restart && idx_ok;

  always_comb begin
    slot_d  = slot_q;
    valid_d = valid_q;
    fill_d  = fill_q;
    peak_d  = peak_q;
    rise_d  = rise_q;
    high_d  = high_q;
    stime_d = stime_q;
    if (cmd_i.exec) begin
      if (restart) begin
        slot_d  = '0;
        valid_d = '0;
        fill_d  = cfg_fill_q;
        peak_d  = '0;
        high_d  = '0;
        for (int k = 0; k < SENSORS; k++) begin
          rise_d[k] = ts_q;
        end
      end else if (idx_ok) begin
        valid_d[addr_q] = 1'b1;
        peak_d[ix]      = rise_c ? value_q : peak_max;
        high_d[ix]      = high_new;
        if (rise_c) begin
          rise_d[ix] = stime_q[slot_q];
        end
        if (last_q) begin
          stime_d[slot_q] = ts_q;
          slot_d          = (next_slot >= eff_len) ? '0 : next_slot[SLOT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      valid_q <= '0;
      fill_q  <= 10'd1023;
      peak_q  <= '0;
      rise_q  <= '0;
      high_q  <= '0;
      stime_q <= '0;
    end else begin
      slot_q  <= slot_d;
      valid_q <= valid_d;
      fill_q  <= fill_d;
      peak_q  <= peak_d;
      rise_q  <= rise_d;
      high_q  <= high_d;
      stime_q <= stime_d;
    end
  end

  // result register
  logic out_valid_q, out_valid_d;
  logic live;

  assign live        = !restart && idx_ok;
  assign out_valid_d = cmd_i.exec ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      sensor_high_o  <= live && high_new;
      rise_found_o   <= live && rise_c;
      signal_found_o <= live && sig_c;
      delta_rise_o   <= live ? delta : '0;
      pulse_time_o   <= (live && pt_sel) ? ptime_raw : '0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.out_stall = out_valid_q && !out_ready_i;

endmodule

// ----- rtl/windowed_rise_pulse_detector_unit.sv -----
// Top level of the windowed rise pulse detector: controller plus datapath.
// out_valid_o is registered: an item is captured and its window slot read in ST_IDLE, then
// updated and its result loaded in ST_EXEC. The unit takes one item at a time, the window RAM
// read followed by its write; a waiting result holds the next item in ST_EXEC until it transfers.
// A restart item takes the same path; per-entry valid bits stand in for the store fill.
// Reset (rst_ni, async, active low) resets the controller, configuration, per-sensor state and
// result valid; the window store reads as 1023 without a clearing pass.
module windowed_rise_pulse_detector_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wrpd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wrpd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            mode_i,
  input  logic [2:0]                      sensor_index_i,
  input  logic [9:0]                      sensor_value_i,
  input  logic [9:0]                      dark_value_i,
  input  logic [31:0]                     timestamp_i,
  input  logic                            last_of_set_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            sensor_high_o,
  output logic                            rise_found_o,
  output logic                            signal_found_o,
  output logic signed [10:0]              delta_rise_o,
  output logic [31:0]                     pulse_time_o
);
  import wrpd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  wrpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wrpd_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .mode_i         (mode_i),
    .sensor_index_i (sensor_index_i),
    .sensor_value_i (sensor_value_i),
    .dark_value_i   (dark_value_i),
    .timestamp_i    (timestamp_i),
    .last_of_set_i  (last_of_set_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sensor_high_o  (sensor_high_o),
    .rise_found_o   (rise_found_o),
    .signal_found_o (signal_found_o),
    .delta_rise_o   (delta_rise_o),
    .pulse_time_o   (pulse_time_o)
  );

endmodule

// ----- rtl/wrpd_checker.sv -----
// Port-level assertions for the detector and the bind that attaches them.
module wrpd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_we_i,
  input logic [wrpd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [wrpd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            mode_i,
  input logic [2:0]                      sensor_index_i,
  input logic [9:0]                      sensor_value_i,
  input logic [9:0]                      dark_value_i,
  input logic [31:0]                     timestamp_i,
  input logic                            last_of_set_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            sensor_high_o,
  input logic                            rise_found_o,
  input logic                            signal_found_o,
  input logic signed [10:0]              delta_rise_o,
  input logic [31:0]                     pulse_time_o
);

  // one item in flight: no second transfer in the cycle after one
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready in cycle after transfer");

  // result valid rises only after its input transfer has passed the capture and execute states
  a_result_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without matching input transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(delta_rise_o)
      && $stable(pulse_time_o))
    else $error("stalled result changed");

  a_flag_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!rise_found_o || sensor_high_o) && (!signal_found_o || rise_found_o))
    else $error("inconsistent result flags");

  a_pulse_time_on_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (pulse_time_o != 32'd0) |-> rise_found_o)
    else $error("pulse time reported without rise");

endmodule

bind windowed_rise_pulse_detector_unit wrpd_checker u_wrpd_checker (.*);

// ----- dv/tb_windowed_rise_pulse_detector_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the windowed rise pulse detector unit.
module tb_windowed_rise_pulse_detector_unit;
  import wrpd_pkg::*;

  typedef struct packed {
    logic        mode;
    logic [2:0]  sensor;
    logic [9:0]  value;
    logic [9:0]  dark;
    logic [31:0] stamp;
    logic        last;
  } sample_t;

  typedef struct packed {
    logic               is_high;
    logic               rising;
    logic               fire;
    logic signed [10:0] delta;
    logic [31:0]        ptime;
  } detection_t;

  typedef struct packed {
    sample_t    stim;
    logic       typed;
    detection_t want;
  } row_t;

  typedef struct packed {
    int          rise;
    int          dip;
    int          peak;
    logic [31:0] pmin;
    logic [31:0] pmax;
    logic [4:0]  wlen;
    logic [9:0]  fill;
  } cfg_t;

  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 90;
  localparam int SAMPLE_W     = $bits(sample_t);

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  mode_i;
  logic [2:0]            sensor_index_i;
  logic [9:0]            sensor_value_i;
  logic [9:0]            dark_value_i;
  logic [31:0]           timestamp_i;
  logic                  last_of_set_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  sensor_high_o;
  logic                  rise_found_o;
  logic                  signal_found_o;
  logic signed [10:0]    delta_rise_o;
  logic [31:0]           pulse_time_o;

  always #5 clk_i = ~clk_i;

  windowed_rise_pulse_detector_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .sensor_index_i (sensor_index_i),
    .sensor_value_i (sensor_value_i),
    .dark_value_i   (dark_value_i),
    .timestamp_i    (timestamp_i),
    .last_of_set_i  (last_of_set_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sensor_high_o  (sensor_high_o),
    .rise_found_o   (rise_found_o),
    .signal_found_o (signal_found_o),
    .delta_rise_o   (delta_rise_o),
    .pulse_time_o   (pulse_time_o)
  );

  // predictor state
  int          rise_thr = 0;
  int          dip_thr  = 0;
  int          peak_thr = 0;
  logic [31:0] pmin_reg = '0;
  logic [31:0] pmax_reg = '0;
  logic [4:0]  wlen_reg = 5'd1;
  logic [9:0]  fill_reg = 10'd1023;

  logic [9:0]  win_mem [WINDOW_DEPTH][SENSORS];
  logic [31:0] slot_ts [WINDOW_DEPTH];
  int          wr_slot;
  logic [9:0]  peak_mem [SENSORS];
  logic [31:0] rise_ts [SENSORS];
  logic        hi_mem [SENSORS];

  detection_t  pending_detections [$];
  int          detections_seen = 0;
  int          errors = 0;

  row_t dir_rows [16] = '{
    '{'{MODE_SAMPLE,  3'd0, 10'd1023, 10'd0,    32'h0000_0000, 1'b0}, 1'b1,
      '{1'b1, 1'b1, 1'b1, 11'sd0, 32'd0}},
    '{'{MODE_SAMPLE,  3'd1, 10'd0,    10'd1023, 32'h0000_0005, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 1'b0, -11'sd1023, 32'd0}},
    '{'{MODE_SAMPLE,  3'd7, 10'd1023, 10'd1023, 32'hFFFF_FFFF, 1'b1}, 1'b0, '0},
    '{'{MODE_SAMPLE,  3'd0, 10'd0,    10'd0,    32'h0000_000A, 1'b0}, 1'b0, '0},
    '{'{MODE_SAMPLE,  3'd0, 10'd1023, 10'd512,  32'h0000_0014, 1'b1}, 1'b0, '0},
    '{'{MODE_RESTART, 3'd7, 10'd1023, 10'd1023, 32'h8000_0000, 1'b1}, 1'b1, '0},
    '{'{MODE_SAMPLE,  3'd2, 10'd1023, 10'd0,    32'h8000_0001, 1'b0}, 1'b0, '0},
    '{'{MODE_SAMPLE,  3'd2, 10'd512,  10'd0,    32'h8000_0002, 1'b0}, 1'b0, '0},
    '{'{MODE_RESTART, 3'd0, 10'd0,    10'd0,    32'h0000_0000, 1'b0}, 1'b1, '0},
    '{'{MODE_SAMPLE,  3'd5, 10'd0,    10'd0,    32'h0000_0000, 1'b1}, 1'b0, '0},
    '{'{MODE_SAMPLE,  3'd4, 10'd1023, 10'd1023, 32'h0000_0000, 1'b0}, 1'b1,
      '{1'b1, 1'b1, 1'b1, 11'sd0, 32'd0}},
    '{'{MODE_SAMPLE,  3'd4, 10'd1023, 10'd0,    32'h0000_0003, 1'b0}, 1'b0, '0},
    '{'{MODE_SAMPLE,  3'd6, 10'd341,  10'd682,  32'h5555_5555, 1'b1}, 1'b0, '0},
    '{'{MODE_SAMPLE,  3'd3, 10'd682,  10'd341,  32'hAAAA_AAAA, 1'b1}, 1'b0, '0},
    '{'{MODE_RESTART, 3'd1, 10'd341,  10'd682,  32'hFFFF_FFFF, 1'b0}, 1'b1, '0},
    '{'{MODE_SAMPLE,  3'd1, 10'd1,    10'd1023, 32'h0000_0000, 1'b1}, 1'b0, '0}
  };

  task automatic flag_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic detection_t predict_detection(sample_t s);
    detection_t  r;
    int          slot;
    int          delta;
    int          span;
    int          idx;
    logic        hi_now;
    logic [31:0] gap;
    r = '0;
    idx = int'(s.sensor);
    if (s.mode == MODE_RESTART) begin
      for (int j = 0; j < WINDOW_DEPTH; j++)
        for (int k = 0; k < SENSORS; k++) win_mem[j][k] = fill_reg;
      for (int k = 0; k < SENSORS; k++) begin
        peak_mem[k] = '0;
        rise_ts[k]  = s.stamp;
        hi_mem[k]   = 1'b0;
      end
      wr_slot = 0;
      return r;
    end
    if (idx >= SENSORS) return r;
    slot  = wr_slot;
    delta = int'(s.value) - int'(win_mem[slot][idx]);
    if (peak_mem[idx] < s.value) peak_mem[idx] = s.value;
    hi_now = hi_mem[idx];
    if (!hi_now) begin
      if (delta >= rise_thr) begin
        hi_now   = 1'b1;
        r.rising = 1'b1;
        if (int'(peak_mem[idx]) - int'(s.dark) >= peak_thr) begin
          gap     = s.stamp - rise_ts[idx];
          r.ptime = gap;
          r.fire  = (gap >= pmin_reg) && (gap <= pmax_reg);
        end
        peak_mem[idx] = s.value;
        rise_ts[idx]  = slot_ts[slot];
      end
    end else if (delta <= dip_thr) begin
      hi_now = 1'b0;
    end
    hi_mem[idx] = hi_now;
    win_mem[slot][idx] = s.value;
    if (s.last) begin
      span = (wlen_reg == 0) ? 1 : ((int'(wlen_reg) > WINDOW_DEPTH) ? WINDOW_DEPTH
                                                                     : int'(wlen_reg));
      slot_ts[slot] = s.stamp;
      wr_slot = (slot + 1 >= span) ? 0 : slot + 1;
    end
    r.is_high = hi_now;
    r.delta   = 11'(delta);
    return r;
  endfunction

  // leaves the write enable high; the caller lowers it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      CFG_RISE_THR:   rise_thr = int'($signed(data[10:0]));
      CFG_DIP_THR:    dip_thr  = int'($signed(data[10:0]));
      CFG_PEAK_THR:   peak_thr = int'($signed(data[10:0]));
      CFG_PULSE_MIN:  pmin_reg = data;
      CFG_PULSE_MAX:  pmax_reg = data;
      CFG_WIN_LEN:    wlen_reg = data[4:0];
      CFG_FILL_VALUE: fill_reg = data[9:0];
      default: ;
    endcase
  endtask

  task automatic offer_sample(sample_t s, logic use_given, detection_t given);
    detection_t guess;
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    mode_i         <= s.mode;
    sensor_index_i <= s.sensor;
    sensor_value_i <= s.value;
    dark_value_i   <= s.dark;
    timestamp_i    <= s.stamp;
    last_of_set_i  <= s.last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    guess = predict_detection(s);
    pending_detections.push_back(use_given ? given : guess);
  endtask

  task automatic idle_sender(int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    idle_sender(1);
    while (pending_detections.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    detection_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      detections_seen++;
      if (pending_detections.size() == 0) begin
        flag_mismatch("result transfer with nothing pending");
      end else begin
        want = pending_detections.pop_front();
        if (sensor_high_o !== want.is_high)
          flag_mismatch($sformatf("sensor_high %0b exp %0b", sensor_high_o, want.is_high));
        if (rise_found_o !== want.rising)
          flag_mismatch($sformatf("rise_found %0b exp %0b", rise_found_o, want.rising));
        if (signal_found_o !== want.fire)
          flag_mismatch($sformatf("signal_found %0b exp %0b", signal_found_o, want.fire));
        if (delta_rise_o !== want.delta)
          flag_mismatch($sformatf("delta_rise %0d exp %0d", delta_rise_o, want.delta));
        if (pulse_time_o !== want.ptime)
          flag_mismatch($sformatf("pulse_time %0h exp %0h", pulse_time_o, want.ptime));
      end
    end
  end

  // receiver: shifting stall patterns plus two long hold-offs
  initial begin : result_sink
    int pat;
    int pat_left;
    int hold_left;
    int holds_done;
    out_ready_i = 1'b0;
    pat = 0;
    pat_left = 0;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && holds_done < 2 && detections_seen >= 300 + 500 * holds_done) begin
        hold_left = 80;
        holds_done++;
      end
      if (pat_left == 0) begin
        pat = $urandom_range(3);
        pat_left = $urandom_range(10, 60);
      end
      pat_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (pat)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(1));
          2: out_ready_i <= ($urandom_range(3) == 0);
          default: out_ready_i <= ($urandom_range(3) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    sample_t     s;
    cfg_t        plan;
    int          burst_left;
    int          gap;
    int          set_size;
    int          next_sensor;
    int          roll;
    logic [31:0] stamp_now;
    logic        lvl_hi [SENSORS];
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    mode_i         = MODE_SAMPLE;
    sensor_index_i = '0;
    sensor_value_i = '0;
    dark_value_i   = '0;
    timestamp_i    = '0;
    last_of_set_i  = 1'b0;
    for (int j = 0; j < WINDOW_DEPTH; j++) begin
      slot_ts[j] = '0;
      for (int k = 0; k < SENSORS; k++) win_mem[j][k] = 10'd1023;
    end
    for (int k = 0; k < SENSORS; k++) begin
      peak_mem[k] = '0;
      rise_ts[k]  = '0;
      hi_mem[k]   = 1'b0;
      lvl_hi[k]   = 1'b0;
    end
    wr_slot = 0;
    burst_left = 0;
    next_sensor = 0;
    stamp_now = $urandom;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) offer_sample(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: plan = '{1023, -1023, 1023, 32'h0, 32'hFFFF_FFFF, 5'd0, 10'd0};
        1: plan = '{-1023, 1023, -1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 10'd1023};
        2: plan = '{0, 0, 0, 32'h0, 32'h0, 5'd16, 10'd512};
        default: begin
          plan.rise = $urandom_range(1, 300);
          plan.dip  = 0 - int'($urandom_range(0, 300));
          plan.peak = int'($urandom_range(0, 600)) - 200;
          plan.pmin = $urandom_range(0, 150);
          plan.pmax = $urandom_range(100, 4000);
          plan.fill = 10'($urandom_range(0, 1023));
          if (ph == 3) plan.wlen = 5'd3;
          else if (ph == 4) plan.wlen = 5'd17;
          else if ($urandom_range(9) == 0) plan.wlen = 5'($urandom_range(17, 31));
          else plan.wlen = 5'($urandom_range(1, 16));
        end
      endcase
      write_reg(CFG_RISE_THR,   32'(plan.rise));
      write_reg(CFG_DIP_THR,    32'(plan.dip));
      write_reg(CFG_PEAK_THR,   32'(plan.peak));
      write_reg(CFG_PULSE_MIN,  plan.pmin);
      write_reg(CFG_PULSE_MAX,  plan.pmax);
      write_reg(CFG_WIN_LEN,    32'(plan.wlen));
      write_reg(CFG_FILL_VALUE, 32'(plan.fill));
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
      if (ph == 4) stamp_now = 32'hFFFF_FF00;
      set_size = $urandom_range(1, SENSORS);
      next_sensor = 0;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
          if (gap > 0) idle_sender(gap);
        end
        burst_left--;
        roll = $urandom_range(99);
        s = SAMPLE_W'({$urandom, $urandom});
        if (roll < 2) begin
          s.mode  = MODE_RESTART;
          s.stamp = stamp_now;
        end else if (roll < 10) begin
          s.mode  = MODE_SAMPLE;
          s.value = 10'($urandom);
          s.dark  = 10'($urandom);
          s.stamp = $urandom;
        end else begin
          if ($urandom_range(99) < 20) lvl_hi[next_sensor] = !lvl_hi[next_sensor];
          s.mode   = MODE_SAMPLE;
          s.sensor = 3'(next_sensor);
          s.value  = lvl_hi[next_sensor] ? 10'($urandom_range(600, 1023))
                                         : 10'($urandom_range(0, 350));
          s.dark   = 10'($urandom_range(0, 400));
          s.stamp  = stamp_now;
          s.last   = (next_sensor == set_size - 1);
          if (s.last) begin
            next_sensor = 0;
            stamp_now = stamp_now + $urandom_range(1, 40);
          end else begin
            next_sensor++;
          end
        end
        offer_sample(s, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
